// ----- rtl/ffsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int ID_BITS      = 16;
	localparam int OWN_W        = (ID_BITS < 16) ? ID_BITS : 16;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int LEN_W        = 21;
	localparam int START_W      = 20;
	localparam int PID_W        = 16;
	localparam int REJ_W        = 16;
	localparam int HOLE_W       = 7;
	localparam int ENTRY_W      = OWN_W + LEN_W + 1;
	localparam int RAM_AW       = IDX_W + 1;
	localparam int RAM_DEPTH    = 2 * MAX_SEGMENTS;
	localparam int IN_W         = 40;
	localparam int OUT_W        = 48;

	localparam logic [LEN_W-1:0] MEM_SIZE_RESET = LEN_W'(1048576);
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_HOLE,
		ST_TOP,
		ST_REJECT,
		ST_FREED,
		ST_NOT_FOUND,
		ST_FULL
	} status_t;

	typedef struct packed {
		logic [OWN_W-1:0] owner;
		logic [LEN_W-1:0] len;
		logic             free;
	} entry_t;

	typedef struct packed {
		logic [HOLE_W-1:0]  holes;
		logic [REJ_W-1:0]   rejected;
		logic [START_W-1:0] start;
		status_t            status;
	} result_t;

endpackage

// ----- rtl/ffsa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/ffsa_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_engine
// Sequencer that streams the segment table from one RAM bank into the other,
// applying an allocate or a free, then swaps the banks unless a free misses.
// ----------------------------------------------------------------------------
module ffsa_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [ffsa_pkg::PID_W-1:0]    process_id,
	input  logic [ffsa_pkg::LEN_W-1:0]    request_size,
	input  logic [ffsa_pkg::LEN_W-1:0]    size_limit,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ffsa_pkg::result_t             res,
	output logic                          ram_we,
	output logic [ffsa_pkg::RAM_AW-1:0]   ram_waddr,
	output ffsa_pkg::entry_t              ram_wdata,
	output logic                          ram_re,
	output logic [ffsa_pkg::RAM_AW-1:0]   ram_raddr,
	input  ffsa_pkg::entry_t              ram_rdata
);
	import ffsa_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_RD, S_PROC, S_SPLIT, S_FIN} state_t;

	state_t             state_q;
	logic               op_q;
	logic [OWN_W-1:0]   id_q;
	logic [LEN_W-1:0]   size_q;
	logic               bank_q;
	logic [CNT_W-1:0]   cnt_q, i_q, j_q, h_q;
	logic [LEN_W-1:0]   top_q, addr_q, start_q, split_len_q, last_len_q;
	logic [REJ_W-1:0]   rej_q;
	logic [HOLE_W-1:0]  holes_q;
	logic               found_q, last_free_q;
	logic [OWN_W-1:0]   last_own_q;
	status_t            st_q;

	entry_t             ent;
	logic               hit, fr, merge, fits_top, split;
	logic [LEN_W-1:0]   sum_len;
	logic [LEN_W:0]     top_sum;
	logic [CNT_W-1:0]   i_nx;
	logic [IDX_W-1:0]   wix;
	status_t            fin_st;
	logic [LEN_W-1:0]   fin_start;

	assign ent      = ram_rdata;
	assign i_nx     = i_q + CNT_W'(1);
	assign sum_len  = last_len_q + ent.len;
	assign top_sum  = {1'b0, top_q} + {1'b0, size_q};
	assign fits_top = top_sum <= {1'b0, size_limit};
	assign in_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign ram_re    = (state_q == S_RD);
	assign ram_raddr = {bank_q, i_q[IDX_W-1:0]};
	assign ram_waddr = {~bank_q, wix};

	always_comb begin
		if (op_q == ACT_ALLOC) begin
			hit = !found_q && ent.free && (ent.len >= size_q);
		end else begin
			hit = !found_q && !ent.free && (ent.owner == id_q);
		end
		fr    = ent.free | hit;
		merge = fr && (j_q != '0) && last_free_q;
		split = (op_q == ACT_ALLOC) && hit && (ent.len != size_q)
			&& (cnt_q != CNT_W'(MAX_SEGMENTS));
	end

	always_comb begin
		fin_st    = st_q;
		fin_start = start_q;
		if (op_q == ACT_ALLOC) begin
			if (!found_q) begin
				if (!fits_top) begin
					fin_st = ST_REJECT;
				end else if (cnt_q == CNT_W'(MAX_SEGMENTS)) begin
					fin_st = ST_FULL;
				end else begin
					fin_st    = ST_TOP;
					fin_start = top_q;
				end
			end
		end else begin
			fin_st = found_q ? ST_FREED : ST_NOT_FOUND;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		wix       = j_q[IDX_W-1:0];
		ram_wdata = ent;
		case (state_q)
			S_PROC: begin
				if (op_q == ACT_ALLOC) begin
					if (hit && ent.len == size_q) begin
						ram_we    = 1'b1;
						ram_wdata = '{owner: id_q, len: ent.len, free: 1'b0};
					end else if (hit && cnt_q != CNT_W'(MAX_SEGMENTS)) begin
						ram_we    = 1'b1;
						ram_wdata = '{owner: id_q, len: size_q, free: 1'b0};
					end else if (!(ent.free && ent.len == '0)) begin
						ram_we = 1'b1;
					end
				end else if (merge) begin
					ram_we    = 1'b1;
					wix       = IDX_W'(j_q - CNT_W'(1));
					ram_wdata = '{owner: last_own_q, len: sum_len, free: 1'b1};
				end else begin
					ram_we    = 1'b1;
					ram_wdata = '{owner: ent.owner, len: ent.len, free: fr};
				end
			end
			S_SPLIT: begin
				ram_we    = 1'b1;
				ram_wdata = '{owner: id_q, len: split_len_q, free: 1'b1};
			end
			S_FIN: begin
				ram_we    = res_ready && (fin_st == ST_TOP);
				ram_wdata = '{owner: id_q, len: size_q, free: 1'b0};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.status   = fin_st;
		res.start    = (fin_st == ST_REJECT || fin_st == ST_NOT_FOUND || fin_st == ST_FULL)
			? '0 : fin_start[START_W-1:0];
		res.rejected = (fin_st == ST_REJECT && rej_q != '1) ? rej_q + REJ_W'(1) : rej_q;
		res.holes    = (fin_st == ST_NOT_FOUND) ? holes_q : HOLE_W'(h_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bank_q      <= 1'b0;
			cnt_q       <= '0;
			top_q       <= '0;
			rej_q       <= '0;
			holes_q     <= '0;
			op_q        <= ACT_ALLOC;
			id_q        <= '0;
			size_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			h_q         <= '0;
			addr_q      <= '0;
			start_q     <= '0;
			split_len_q <= '0;
			last_len_q  <= '0;
			last_own_q  <= '0;
			found_q     <= 1'b0;
			last_free_q <= 1'b0;
			st_q        <= ST_HOLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q        <= action;
						id_q        <= process_id[OWN_W-1:0];
						size_q      <= request_size;
						i_q         <= '0;
						j_q         <= '0;
						h_q         <= '0;
						addr_q      <= '0;
						start_q     <= '0;
						found_q     <= 1'b0;
						last_free_q <= 1'b0;
						st_q        <= ST_HOLE;
						state_q     <= (cnt_q == '0) ? S_FIN : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_PROC;
				end
				S_PROC: begin
					i_q     <= i_nx;
					addr_q  <= addr_q + ent.len;
					state_q <= split ? S_SPLIT : ((i_nx == cnt_q) ? S_FIN : S_RD);
					if (hit) begin
						found_q <= 1'b1;
						start_q <= addr_q;
					end
					if (op_q == ACT_ALLOC) begin
						if (hit && ent.len == size_q) begin
							j_q <= j_q + CNT_W'(1);
						end else if (split) begin
							j_q         <= j_q + CNT_W'(1);
							split_len_q <= ent.len - size_q;
						end else begin
							if (hit) begin
								st_q <= ST_FULL;
							end
							if (!(ent.free && ent.len == '0)) begin
								j_q <= j_q + CNT_W'(1);
								if (ent.free) begin
									h_q <= h_q + CNT_W'(1);
								end
							end
						end
					end else if (merge) begin
						last_len_q <= sum_len;
					end else begin
						j_q         <= j_q + CNT_W'(1);
						last_free_q <= fr;
						last_len_q  <= ent.len;
						last_own_q  <= ent.owner;
						if (fr) begin
							h_q <= h_q + CNT_W'(1);
						end
					end
				end
				S_SPLIT: begin
					j_q     <= j_q + CNT_W'(1);
					h_q     <= h_q + CNT_W'(1);
					state_q <= (i_q == cnt_q) ? S_FIN : S_RD;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
						rej_q   <= res.rejected;
						if (fin_st != ST_NOT_FOUND) begin
							bank_q  <= ~bank_q;
							holes_q <= HOLE_W'(h_q);
							cnt_q   <= (fin_st == ST_TOP) ? j_q + CNT_W'(1) : j_q;
						end
						if (fin_st == ST_TOP) begin
							top_q <= top_sum[LEN_W-1:0];
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/first_fit_segment_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit segment allocator with coalescing of free neighbors.
// ----------------------------------------------------------------------------
// Each request rewrites the segment table from one half of a single RAM into
// the other half. Every entry is read in S_RD and handled in S_PROC, since
// the RAM read is registered; splitting a hole adds an S_SPLIT step. The
// next request is taken while a result still waits in the output register.
module first_fit_segment_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// action[0], process_id[16:1], request_size[37:17], zero fill.
	input  logic [ffsa_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status[2:0], start_address[22:3], rejected_total[38:23],
	// hole_total[45:39], zero fill.
	output logic [ffsa_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ffsa_pkg::LEN_W-1:0]    cfg_data
);
	import ffsa_pkg::*;

	logic [LEN_W-1:0] size_limit_q;
	logic             res_valid, res_ready;
	result_t          res, out_q;
	logic             ram_we, ram_re;
	logic [RAM_AW-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;
	logic             out_valid_q;

	assign cfg_ready     = 1'b1;
	assign res_ready     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= MEM_SIZE_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_limit_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	ffsa_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.action       (s_axis_tdata[0]),
		.process_id   (s_axis_tdata[PID_W:1]),
		.request_size (s_axis_tdata[PID_W+LEN_W:PID_W+1]),
		.size_limit   (size_limit_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	ffsa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == ST_REJECT || out_q.status == ST_NOT_FOUND ||
		out_q.status == ST_FULL) |-> out_q.start == '0)
		else $error("Failed request reports a nonzero start address.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.holes <= HOLE_W'(MAX_SEGMENTS))
		else $error("Hole count exceeds the table depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr[RAM_AW-1] != ram_raddr[RAM_AW-1])
		else $error("Table read and write hit the same bank.");

endmodule
